/* rtl/lin_frame_checker_assert.svh */
// ----------------------------------------------------------------------------
// LIN frame checker assertion macros
// Shared concurrent assertion forms, clocked and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef LIN_FRAME_CHECKER_ASSERT_SVH
`define LIN_FRAME_CHECKER_ASSERT_SVH

// Same-cycle implication
`define LFC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define LFC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/lfc_pkg.sv */
// ----------------------------------------------------------------------------
// LIN frame checker package
// Item and record types, checksum variant codes and fixed constants.
// ----------------------------------------------------------------------------
package lfc_pkg;

    localparam int BYTE_W       = 8;
    localparam int ID_W         = 6;
    localparam int DATA_COUNT_W = 4;

    // Diagnostic identifiers, always classic checksum
    localparam logic [ID_W-1:0] DIAG_ID_A = 6'h3C;
    localparam logic [ID_W-1:0] DIAG_ID_B = 6'h3D;

    // Settled checksum variant codes
    localparam logic [1:0] VAR_UNKNOWN  = 2'd0;
    localparam logic [1:0] VAR_CLASSIC  = 2'd1;
    localparam logic [1:0] VAR_ENHANCED = 2'd2;

    typedef struct packed {
        logic [BYTE_W-1:0] byte_value;
        logic              starts_frame;
        logic              ends_frame;
        logic              truncated;
    } lfc_item_t;

    typedef struct packed {
        logic                    frame_cut;
        logic                    no_response;
        logic                    enhanced_used;
        logic                    checksum_ok;
        logic [BYTE_W-1:0]       received_checksum;
        logic [DATA_COUNT_W-1:0] data_count;
        logic                    parity_match;
        logic [BYTE_W-1:0]       protected_id;
        logic [ID_W-1:0]         identifier;
    } lfc_record_t;

    // Ones-complement byte add with end-around carry
    function automatic logic [BYTE_W-1:0] oc_add(input logic [BYTE_W-1:0] a,
                                                 input logic [BYTE_W-1:0] b);
        logic [BYTE_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[BYTE_W-1:0] + {{(BYTE_W-1){1'b0}}, s[BYTE_W]};
    endfunction

    // Both PID parity bits match the identifier
    function automatic logic pid_parity_match(input logic [BYTE_W-1:0] pid);
        logic p0;
        logic p1;
        p0 = pid[0] ^ pid[1] ^ pid[2] ^ pid[4];
        p1 = ~(pid[1] ^ pid[3] ^ pid[4] ^ pid[5]);
        return (pid[6] == p0) && (pid[7] == p1);
    endfunction

endpackage

/* rtl/lin_frame_checker.sv */
// ----------------------------------------------------------------------------
// LIN frame checker
// PID parity and classic/enhanced checksum check, one frame record per closed frame.
// ----------------------------------------------------------------------------
// Takes one decoded LIN byte per transfer (PID first, checksum last) and
// sends one record per closed frame. A byte passes an input register, then
// the frame state and checksum update, then a result register: one byte is
// taken every clock cycle while the result slot is free or being read, the
// record enters the result register as the closing byte leaves the input
// register, and the rate is set by the running-sum update in lfc_frame_core.
// The input side keeps accepting while a record waits to be taken; it stalls
// only when both the input register and the result register are full.
`include "lin_frame_checker_assert.svh"

module lin_frame_checker import lfc_pkg::*; #(
    parameter int MAX_DATA_BYTES = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] byte_value
    input  logic [1:0]  s_axis_tuser,   // [0] starts_frame, [1] truncated
    input  logic        s_axis_tlast,   // ends_frame
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [5:0] identifier, [13:6] protected_id, [14] parity_match, [18:15] data_count,
    // [26:19] received_checksum, [27] checksum_ok, [28] enhanced_used,
    // [29] no_response, [30] frame_cut, [31] zero
    output logic [31:0] m_axis_tdata
);

    logic        in_valid_reg;
    lfc_item_t   in_item_reg;
    logic        consume;
    logic        emit;
    lfc_record_t record;
    logic        out_valid_reg;
    lfc_record_t out_record_reg;

    // Item leaves the input register when a result slot is free
    assign consume       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || consume;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_item_reg.byte_value   <= s_axis_tdata;
            in_item_reg.starts_frame <= s_axis_tuser[0];
            in_item_reg.ends_frame   <= s_axis_tlast;
            in_item_reg.truncated    <= s_axis_tuser[1];
        end
    end

    lfc_frame_core #(
        .MAX_DATA_BYTES (MAX_DATA_BYTES)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (consume),
        .item   (in_item_reg),
        .emit   (emit),
        .record (record)
    );

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (consume && emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (consume && emit)
        begin
            out_record_reg <= record;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, out_record_reg};

    // Checks
    `LFC_ASSERT_NOW(a_full_stall, clk, rst_n,
        in_valid_reg && out_valid_reg && !m_axis_tready, !s_axis_tready,
        "input taken while both stages are full")
    `LFC_ASSERT_NOW(a_enh_needs_ok, clk, rst_n,
        out_valid_reg && out_record_reg.enhanced_used, out_record_reg.checksum_ok,
        "enhanced flagged without a checksum match")
    `LFC_ASSERT_NOW(a_diag_classic, clk, rst_n,
        out_valid_reg && out_record_reg.enhanced_used,
        (out_record_reg.identifier != DIAG_ID_A) &&
        (out_record_reg.identifier != DIAG_ID_B),
        "diagnostic frame matched as enhanced")
    `LFC_ASSERT_NOW(a_no_resp, clk, rst_n,
        out_valid_reg && out_record_reg.no_response,
        !out_record_reg.checksum_ok && (out_record_reg.data_count == '0) &&
        !out_record_reg.frame_cut,
        "no-response record with response content")
    `LFC_ASSERT_NEXT(a_record_load, clk, rst_n,
        consume && emit, out_valid_reg && (out_record_reg == $past(record)),
        "frame record not loaded into the result register")

endmodule

/* rtl/lfc_frame_core.sv */
// ----------------------------------------------------------------------------
// LIN frame checker core
// Frame state, running checksums and the frame record, one byte a cycle while stepped.
// ----------------------------------------------------------------------------
module lfc_frame_core import lfc_pkg::*; #(
    parameter int MAX_DATA_BYTES = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        step,
    input  lfc_item_t   item,
    output logic        emit,
    output lfc_record_t record
);

    localparam int RESP_CNT_W = $clog2(MAX_DATA_BYTES + 2);
    localparam logic [RESP_CNT_W-1:0] RESP_MAX = RESP_CNT_W'(MAX_DATA_BYTES + 1);

    logic [BYTE_W-1:0]     classic_sum_reg,  classic_sum_next;
    logic [BYTE_W-1:0]     enhanced_sum_reg, enhanced_sum_next;
    logic [BYTE_W-1:0]     pending_byte_reg, pending_byte_next;
    logic [RESP_CNT_W-1:0] resp_count_reg,   resp_count_next;
    logic [BYTE_W-1:0]     held_pid_reg,     held_pid_next;
    logic [1:0]            settled_reg,      settled_next;
    logic                  in_frame_reg,     in_frame_next;

    logic              diag;
    logic              has_resp;
    logic [BYTE_W-1:0] rx;
    logic [BYTE_W-1:0] want_cls;
    logic [BYTE_W-1:0] want_enh;
    logic              enh_first;
    logic              ok;
    logic              enh;

    // Running sums and frame bookkeeping
    always_comb
    begin
        classic_sum_next  = classic_sum_reg;
        enhanced_sum_next = enhanced_sum_reg;
        pending_byte_next = pending_byte_reg;
        resp_count_next   = resp_count_reg;
        held_pid_next     = held_pid_reg;
        emit              = 1'b0;
        if (item.starts_frame)
        begin
            held_pid_next     = item.byte_value;
            classic_sum_next  = '0;
            enhanced_sum_next = item.byte_value;
            pending_byte_next = '0;
            resp_count_next   = '0;
            emit              = item.ends_frame;
        end
        else if (in_frame_reg)
        begin
            emit = item.ends_frame;
            // bytes past the checksum slot are dropped
            if (resp_count_reg < RESP_MAX)
            begin
                if (resp_count_reg != '0)
                begin
                    classic_sum_next  = oc_add(classic_sum_reg, pending_byte_reg);
                    enhanced_sum_next = oc_add(enhanced_sum_reg, pending_byte_reg);
                end
                pending_byte_next = item.byte_value;
                resp_count_next   = resp_count_reg + 1'b1;
            end
        end
    end

    // Checksum compare, settled variant tried first
    always_comb
    begin
        diag      = (held_pid_next[ID_W-1:0] == DIAG_ID_A) ||
                    (held_pid_next[ID_W-1:0] == DIAG_ID_B);
        has_resp  = (resp_count_next != '0);
        rx        = has_resp ? pending_byte_next : '0;
        want_cls  = ~classic_sum_next;
        want_enh  = ~enhanced_sum_next;
        enh_first = !diag && (settled_reg != VAR_CLASSIC);
        ok        = 1'b0;
        enh       = 1'b0;
        if (has_resp)
        begin
            if (rx == (enh_first ? want_enh : want_cls))
            begin
                ok  = 1'b1;
                enh = enh_first;
            end
            else if (!diag && (rx == (enh_first ? want_cls : want_enh)))
            begin
                ok  = 1'b1;
                enh = !enh_first;
            end
        end

        settled_next = settled_reg;
        if (emit && ok && !diag)
        begin
            settled_next = enh ? VAR_ENHANCED : VAR_CLASSIC;
        end

        in_frame_next = in_frame_reg;
        if (item.starts_frame)
        begin
            in_frame_next = 1'b1;
        end
        if (emit)
        begin
            in_frame_next = 1'b0;
        end
    end

    // Frame record
    always_comb
    begin
        record.identifier        = held_pid_next[ID_W-1:0];
        record.protected_id      = held_pid_next;
        record.parity_match      = pid_parity_match(held_pid_next);
        record.data_count        = has_resp ?
                                   DATA_COUNT_W'(resp_count_next - 1'b1) : '0;
        record.received_checksum = rx;
        record.checksum_ok       = ok;
        record.enhanced_used     = enh;
        record.no_response       = !has_resp && !item.truncated;
        record.frame_cut         = item.truncated;
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            classic_sum_reg  <= '0;
            enhanced_sum_reg <= '0;
            pending_byte_reg <= '0;
            resp_count_reg   <= '0;
            held_pid_reg     <= '0;
            settled_reg      <= VAR_UNKNOWN;
            in_frame_reg     <= 1'b0;
        end
        else if (step)
        begin
            classic_sum_reg  <= classic_sum_next;
            enhanced_sum_reg <= enhanced_sum_next;
            pending_byte_reg <= pending_byte_next;
            resp_count_reg   <= resp_count_next;
            held_pid_reg     <= held_pid_next;
            settled_reg      <= settled_next;
            in_frame_reg     <= in_frame_next;
        end
    end

endmodule

/* test/tb.sv */
// ----------------------------------------------------------------------------
// LIN frame checker testbench
// Drives decoded LIN bytes into lin_frame_checker and checks every frame
// record against an in-bench frame tracker: PID parity, checksum variant
// choice (settled classic/enhanced, diagnostic IDs classic only), response
// counting, over-length frames, dropped frames, truncation and no-response
// flags. A short directed table comes first, then random frames, with random
// idle bursts on both stream sides.
// ----------------------------------------------------------------------------
module tb;
    import lfc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_DATA = 8;

    // Directed stimulus row; rec is used only when typed is set
    typedef struct {
        logic [7:0]  value;
        logic        st;
        logic        lst;
        logic        ct;
        bit          typed;
        lfc_record_t rec;
    } dir_row_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;   // [7:0] byte_value
    logic [1:0]  s_axis_tuser;   // [0] starts_frame, [1] truncated
    logic        s_axis_tlast;   // ends_frame
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;   // frame record, see lfc_record_t; [31] zero

    // Frame tracker state
    logic [7:0] cls_sum;
    logic [7:0] enh_sum;
    logic [7:0] last_rx;
    logic [3:0] rsp_cnt;
    logic [7:0] pid_hold;
    logic [1:0] variant;
    logic       frame_open;

    lfc_record_t pending_records[$];
    lfc_record_t want_rec;
    lfc_record_t got_rec;
    dir_row_t    dir_rows[25];

    int fail_cnt  = 0;
    int gap_pct   = 25;
    int stall_pct = 25;
    bit quiet     = 1'b0;

    lin_frame_checker #(
        .MAX_DATA_BYTES(MAX_DATA)
    ) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .s_axis_tlast (s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    // 100 MHz clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Run time limit
    initial
    begin
        #2_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    // Ones-complement add, end-around carry
    function automatic logic [7:0] ones_add(input logic [7:0] a, input logic [7:0] b);
        logic [8:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s > 9'h0FF)
            s = s - 9'h0FF;
        return s[7:0];
    endfunction

    // Identifier with its two parity bits on top
    function automatic logic [7:0] pid_of(input logic [5:0] id);
        logic p0;
        logic p1;
        p0 = id[0] ^ id[1] ^ id[2] ^ id[4];
        p1 = ~(id[1] ^ id[3] ^ id[4] ^ id[5]);
        return {p1, p0, id};
    endfunction

    function automatic lfc_record_t frame_rec(input logic [7:0] pid, input logic par,
                                              input logic [3:0] dc, input logic [7:0] rx,
                                              input logic ok, input logic enh,
                                              input logic nr, input logic cut);
        lfc_record_t r;
        r.identifier        = pid[5:0];
        r.protected_id      = pid;
        r.parity_match      = par;
        r.data_count        = dc;
        r.received_checksum = rx;
        r.checksum_ok       = ok;
        r.enhanced_used     = enh;
        r.no_response       = nr;
        r.frame_cut         = cut;
        return r;
    endfunction

    // Tracks one accepted byte; returns 1 with the frame record when it closes a frame
    function automatic bit track_lin_byte(input logic [7:0] b, input logic st,
                                          input logic lst, input logic ct,
                                          output lfc_record_t rec);
        logic [5:0] id;
        logic [7:0] rx;
        logic [7:0] want_cls;
        logic [7:0] want_enh;
        logic       diag;
        logic       first_enh;
        logic       ok;
        logic       enh;
        rec = '0;
        if (st)
        begin
            pid_hold   = b;
            cls_sum    = 8'h00;
            enh_sum    = b;
            last_rx    = 8'h00;
            rsp_cnt    = 4'd0;
            frame_open = 1'b1;
        end
        else
        begin
            if (!frame_open)
                return 1'b0;
            // bytes past data plus checksum are dropped
            if (rsp_cnt < 4'(MAX_DATA + 1))
            begin
                if (rsp_cnt != 4'd0)
                begin
                    cls_sum = ones_add(cls_sum, last_rx);
                    enh_sum = ones_add(enh_sum, last_rx);
                end
                last_rx = b;
                rsp_cnt = rsp_cnt + 4'd1;
            end
        end
        if (!lst)
            return 1'b0;

        // Close the frame
        id        = pid_hold[5:0];
        diag      = (id == DIAG_ID_A) || (id == DIAG_ID_B);
        rx        = (rsp_cnt != 4'd0) ? last_rx : 8'h00;
        want_cls  = ~cls_sum;
        want_enh  = ~enh_sum;
        first_enh = !diag && (variant != VAR_CLASSIC);
        ok        = 1'b0;
        enh       = 1'b0;
        if (rsp_cnt != 4'd0)
        begin
            if (rx == (first_enh ? want_enh : want_cls))
            begin
                ok  = 1'b1;
                enh = first_enh;
            end
            else if (!diag && rx == (first_enh ? want_cls : want_enh))
            begin
                ok  = 1'b1;
                enh = !first_enh;
            end
        end
        if (ok && !diag)
            variant = enh ? VAR_ENHANCED : VAR_CLASSIC;
        rec = frame_rec(pid_hold, pid_hold == pid_of(id),
                        (rsp_cnt != 4'd0) ? rsp_cnt - 4'd1 : 4'd0, rx, ok, enh,
                        (rsp_cnt == 4'd0) && !ct, ct);
        frame_open = 1'b0;
        return 1'b1;
    endfunction

    // One byte transfer, then an optional idle burst
    task automatic send_byte(input logic [7:0] v, input logic st, input logic lst,
                             input logic ct, input bit typed = 1'b0,
                             input lfc_record_t fixed = '0);
        lfc_record_t rec;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= v;
        s_axis_tuser  <= {ct, st};
        s_axis_tlast  <= lst;
        do
            @(posedge clk);
        while (!s_axis_tready);
        if (track_lin_byte(v, st, lst, ct, rec))
            pending_records.push_back(typed ? fixed : rec);
        if (!quiet && $urandom_range(0, 99) < gap_pct)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fail_cnt++;
        end
    endtask

    // Record sink backpressure
    initial
    begin
        m_axis_tready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (!quiet && $urandom_range(0, 99) < stall_pct)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
        end
    end

    // Record checker
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_records.size() == 0)
            begin
                $error("frame record 0x%08h with none expected", m_axis_tdata);
                fail_cnt++;
            end
            else
            begin
                want_rec = pending_records.pop_front();
                got_rec  = lfc_record_t'(m_axis_tdata[30:0]);
                check_field("identifier", want_rec.identifier, got_rec.identifier);
                check_field("protected_id", want_rec.protected_id, got_rec.protected_id);
                check_field("parity_match", want_rec.parity_match, got_rec.parity_match);
                check_field("data_count", want_rec.data_count, got_rec.data_count);
                check_field("received_checksum", want_rec.received_checksum,
                            got_rec.received_checksum);
                check_field("checksum_ok", want_rec.checksum_ok, got_rec.checksum_ok);
                check_field("enhanced_used", want_rec.enhanced_used, got_rec.enhanced_used);
                check_field("no_response", want_rec.no_response, got_rec.no_response);
                check_field("frame_cut", want_rec.frame_cut, got_rec.frame_cut);
                check_field("tdata[31]", 0, m_axis_tdata[31]);
            end
        end
    end

    // Stimulus
    initial
    begin
        int         items;
        int         sel;
        int         n_data;
        int         n_extra;
        int         next_phase;
        int         wait_cnt;
        bit         pid_only;
        bit         left_open;
        bit         pressed;
        logic       cut_end;
        logic [5:0] id;
        logic [7:0] pid;
        logic [7:0] cls;
        logic [7:0] enh;
        logic [7:0] d;
        logic [7:0] cs;

        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= 8'h00;
        s_axis_tuser  <= 2'b00;
        s_axis_tlast  <= 1'b0;
        rst_n         <= 1'b0;
        cls_sum    = 8'h00;
        enh_sum    = 8'h00;
        last_rx    = 8'h00;
        rsp_cnt    = 4'd0;
        pid_hold   = 8'h00;
        variant    = VAR_UNKNOWN;
        frame_open = 1'b0;

        dir_rows = '{
            // byte outside a frame, even with end set
            '{8'hAA, 1'b0, 1'b1, 1'b0, 1'b0, '0},
            // PID only, id 0
            '{8'h80, 1'b1, 1'b1, 1'b0, 1'b1,
              frame_rec(8'h80, 1'b1, 4'd0, 8'h00, 1'b0, 1'b0, 1'b1, 1'b0)},
            // PID only, bad parity, cut
            '{8'hFF, 1'b1, 1'b1, 1'b1, 1'b1,
              frame_rec(8'hFF, 1'b0, 4'd0, 8'h00, 1'b0, 1'b0, 1'b0, 1'b1)},
            // diagnostic id, classic checksum
            '{8'h3C, 1'b1, 1'b0, 1'b0, 1'b0, '0},
            '{8'hFF, 1'b0, 1'b0, 1'b0, 1'b0, '0},
            '{8'h00, 1'b0, 1'b1, 1'b0, 1'b1,
              frame_rec(8'h3C, 1'b1, 4'd1, 8'h00, 1'b1, 1'b0, 1'b0, 1'b0)},
            // unknown variant: enhanced matches first
            '{8'hC1, 1'b1, 1'b0, 1'b0, 1'b0, '0},
            '{8'h01, 1'b0, 1'b0, 1'b0, 1'b0, '0},
            '{8'h3D, 1'b0, 1'b1, 1'b0, 1'b1,
              frame_rec(8'hC1, 1'b1, 4'd1, 8'h3D, 1'b1, 1'b1, 1'b0, 1'b0)},
            // enhanced settled, classic matches second
            '{8'hC1, 1'b1, 1'b0, 1'b0, 1'b0, '0},
            '{8'h01, 1'b0, 1'b0, 1'b0, 1'b0, '0},
            '{8'hFE, 1'b0, 1'b1, 1'b0, 1'b1,
              frame_rec(8'hC1, 1'b1, 4'd1, 8'hFE, 1'b1, 1'b0, 1'b0, 1'b0)},
            // eight 0xFF data bytes (carry wrap), truncated mid-frame, one extra byte
            '{8'hBF, 1'b1, 1'b0, 1'b0, 1'b0, '0},
            '{8'hFF, 1'b0, 1'b0, 1'b0, 1'b0, '0},
            '{8'hFF, 1'b0, 1'b0, 1'b1, 1'b0, '0},
            '{8'hFF, 1'b0, 1'b0, 1'b0, 1'b0, '0},
            '{8'hFF, 1'b0, 1'b0, 1'b0, 1'b0, '0},
            '{8'hFF, 1'b0, 1'b0, 1'b0, 1'b0, '0},
            '{8'hFF, 1'b0, 1'b0, 1'b0, 1'b0, '0},
            '{8'hFF, 1'b0, 1'b0, 1'b0, 1'b0, '0},
            '{8'hFF, 1'b0, 1'b0, 1'b0, 1'b0, '0},
            '{8'h40, 1'b0, 1'b0, 1'b0, 1'b0, '0},
            '{8'h55, 1'b0, 1'b1, 1'b0, 1'b0, '0},
            // open frame dropped by a new PID-only frame
            '{8'h80, 1'b1, 1'b0, 1'b0, 1'b0, '0},
            '{8'hC1, 1'b1, 1'b1, 1'b0, 1'b1,
              frame_rec(8'hC1, 1'b1, 4'd0, 8'h00, 1'b0, 1'b0, 1'b1, 1'b0)}
        };

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table
        foreach (dir_rows[i])
            send_byte(dir_rows[i].value, dir_rows[i].st, dir_rows[i].lst, dir_rows[i].ct,
                      dir_rows[i].typed, dir_rows[i].rec);

        // Random frames
        items      = 0;
        next_phase = 100;
        left_open  = 1'b0;
        pressed    = 1'b0;
        while (items < 600)
        begin
            // new idle profile every hundred bytes, quiet near the end
            if (items >= next_phase)
            begin
                next_phase += 100;
                sel       = $urandom_range(0, 2);
                gap_pct   = (sel == 0) ? 0 : (sel == 1) ? 15 : 50;
                sel       = $urandom_range(0, 2);
                stall_pct = (sel == 0) ? 0 : (sel == 1) ? 20 : 60;
            end
            quiet = (items >= 520);

            // drain all records once mid-run
            if (!pressed && items >= 300)
            begin
                pressed = 1'b1;
                s_axis_tvalid <= 1'b0;
                while (pending_records.size() != 0)
                    @(posedge clk);
            end

            sel = $urandom_range(0, 99);
            if (sel < 5 && !left_open)
            begin
                // noise with no frame open
                repeat ($urandom_range(1, 3))
                    send_byte(8'($urandom_range(0, 255)), 1'b0, 1'($urandom_range(0, 1)),
                              1'($urandom_range(0, 1)));
            end
            else if (sel < 12)
            begin
                // frame left open, dropped by the next PID
                send_byte(8'($urandom_range(0, 255)), 1'b1, 1'b0, 1'($urandom_range(0, 1)));
                items++;
                repeat ($urandom_range(0, 3))
                begin
                    send_byte(8'($urandom_range(0, 255)), 1'b0, 1'b0,
                              1'($urandom_range(0, 1)));
                    items++;
                end
                left_open = 1'b1;
            end
            else
            begin
                // well-formed frame with random content
                if ($urandom_range(0, 99) < 15)
                    id = $urandom_range(0, 1) ? DIAG_ID_A : DIAG_ID_B;
                else
                    id = 6'($urandom_range(0, 63));
                pid = ($urandom_range(0, 99) < 85) ? pid_of(id) : 8'($urandom_range(0, 255));
                sel      = $urandom_range(0, 99);
                pid_only = (sel < 5);
                n_data   = (sel < 10) ? 0 : (sel < 18) ? MAX_DATA : $urandom_range(1, MAX_DATA);
                n_extra  = (sel >= 10 && sel < 18) ? $urandom_range(1, 2) : 0;
                cut_end  = ($urandom_range(0, 9) == 0);

                send_byte(pid, 1'b1, pid_only, pid_only ? cut_end : ($urandom_range(0, 9) == 0));
                items++;
                if (!pid_only)
                begin
                    cls = 8'h00;
                    enh = pid;
                    repeat (n_data)
                    begin
                        d = 8'($urandom_range(0, 255));
                        send_byte(d, 1'b0, 1'b0, ($urandom_range(0, 9) == 0));
                        cls = ones_add(cls, d);
                        enh = ones_add(enh, d);
                        items++;
                    end
                    sel = $urandom_range(0, 9);
                    cs  = (sel < 4) ? ~enh : (sel < 8) ? ~cls : 8'($urandom_range(0, 255));
                    send_byte(cs, 1'b0, (n_extra == 0),
                              (n_extra == 0) ? cut_end : ($urandom_range(0, 9) == 0));
                    items++;
                    for (int k = 0; k < n_extra; k++)
                    begin
                        send_byte(8'($urandom_range(0, 255)), 1'b0, (k == n_extra - 1),
                                  (k == n_extra - 1) ? cut_end : 1'($urandom_range(0, 1)));
                        items++;
                    end
                end
                left_open = 1'b0;
            end
        end

        // Drain
        s_axis_tvalid <= 1'b0;
        for (wait_cnt = 0; pending_records.size() != 0 && wait_cnt < 2000; wait_cnt++)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (pending_records.size() != 0)
        begin
            $error("%0d frame records never arrived", pending_records.size());
            fail_cnt++;
        end

        if (fail_cnt == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

/* lin_frame_checker.f */
+incdir+rtl
rtl/lfc_pkg.sv
rtl/lfc_frame_core.sv
rtl/lin_frame_checker.sv
test/tb.sv
